>>> rtl/pd_line_follow_steering_core_defines.svh
// ----------------------------------------------------------------------------
// pd_line_follow_steering_core_defines.svh
// Assertion macros shared by the steering core RTL.
// ----------------------------------------------------------------------------
`ifndef PD_LINE_FOLLOW_STEERING_CORE_DEFINES_SVH
`define PD_LINE_FOLLOW_STEERING_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, off while arst_n is low
`define PDLF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low
`define PDLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pdlf_pkg.sv
// ----------------------------------------------------------------------------
// pdlf_pkg
// Widths, register indexes and reset values of the line-follow steering core.
// ----------------------------------------------------------------------------
package pdlf_pkg;

	// Default sample resolution of the reflectance converters
	localparam int SampleBitsDef = 12;

	// Fixed field widths
	localparam int SampleW = 12;
	localparam int GainW   = 8;
	localparam int LevelW  = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 16;
	localparam int InDataW  = 24;
	localparam int OutDataW = 32;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_LEFT_THRESHOLD  = 3'd0,
		REG_RIGHT_THRESHOLD = 3'd1,
		REG_PROP_GAIN       = 3'd2,
		REG_DERIV_GAIN      = 3'd3,
		REG_GAIN_DIVISOR    = 3'd4,
		REG_BASE_LEVEL      = 3'd5,
		REG_MAX_LEVEL       = 3'd6,
		REG_BACK_LEVEL      = 3'd7
	} cfg_reg_t;

	// Reset values of the gains
	localparam logic [GainW-1:0] PropGainRst = 8'd1;
	localparam logic [GainW-1:0] DerivGainRst = 8'd0;
	localparam logic [GainW-1:0] GainDivRst = 8'd1;

endpackage

>>> rtl/pd_line_follow_steering_core.sv
// ----------------------------------------------------------------------------
// pd_line_follow_steering_core
// PD differential steering from a pair of reflectance samples.
// ----------------------------------------------------------------------------
// Each input word carries a left and a right sample; each produces exactly one
// output word. When neither sample is above its threshold both wheels reverse
// at back_level and the stored error is kept; otherwise the PD correction,
// divided by gain_divisor with truncation toward zero, steers base_level down
// on the left and up on the right, each clamped to 0..max_level. An item holds
// the block from acceptance until its word is in the output register, its time
// set mostly by the bit-serial restoring divider that produces one quotient bit
// per cycle. An item passes the error, multiply, sum, divide, clamp and done
// states; a lost-line item goes from the error state straight to done.
// s_tready is high only between items; a finished item waits in its last
// state while the output register still holds an earlier word that the sink
// has not taken.
`include "pd_line_follow_steering_core_defines.svh"

module pd_line_follow_steering_core #(
	parameter int SAMPLE_BITS = pdlf_pkg::SampleBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port
	input  logic                          cfg_we,
	input  logic [pdlf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pdlf_pkg::CfgW-1:0]     cfg_wdata,
	// Sample stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pdlf_pkg::InDataW-1:0]  s_tdata,   // [11:0] left_sample, [23:12] right_sample
	input  logic                          s_tuser,   // [0] clear_history
	// Drive stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pdlf_pkg::OutDataW-1:0] m_tdata,   // [15:0] left_level, [31:16] right_level
	output logic                          m_tuser    // [0] drive_dir
);

	localparam int ErrW   = SAMPLE_BITS + 1;
	localparam int DeltaW = SAMPLE_BITS + 2;
	localparam int MagW   = SAMPLE_BITS + 10;
	localparam int SumW   = MagW + 1;
	localparam int ProdW  = SumW;
	localparam int ResW   = MagW + 2;
	localparam int CntW   = $clog2(MagW + 1);
	localparam int GainW  = pdlf_pkg::GainW;
	localparam int LevelW = pdlf_pkg::LevelW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_CLAMP,
		ST_DONE
	} state_t;

	// Configuration registers
	logic [pdlf_pkg::SampleW-1:0] left_thr_q;
	logic [pdlf_pkg::SampleW-1:0] right_thr_q;
	logic [GainW-1:0]             prop_q;
	logic [GainW-1:0]             deriv_q;
	logic [GainW-1:0]             gdiv_q;
	logic [LevelW-1:0]            base_q;
	logic [LevelW-1:0]            max_q;
	logic [LevelW-1:0]            back_q;

	// Sequencer and datapath
	state_t                   state_q;
	logic [SAMPLE_BITS-1:0]   left_q;
	logic [SAMPLE_BITS-1:0]   right_q;
	logic                     clear_q;
	logic                     lost_q;
	logic signed [ErrW-1:0]   prev_error_q;
	logic signed [ErrW-1:0]   err_q;
	logic signed [DeltaW-1:0] delta_q;
	logic signed [ProdW-1:0]  prod_p_q;
	logic signed [ProdW-1:0]  prod_d_q;
	logic                     neg_q;
	logic [MagW-1:0]          quot_q;
	logic [GainW-1:0]         rem_q;
	logic [GainW-1:0]         div_q;
	logic [CntW-1:0]          cnt_q;
	logic [LevelW-1:0]        left_lvl_q;
	logic [LevelW-1:0]        right_lvl_q;
	logic                     m_tvalid_q;
	logic                     m_tuser_q;
	logic [LevelW-1:0]        m_left_q;
	logic [LevelW-1:0]        m_right_q;

	// Combinational helpers
	logic [SAMPLE_BITS-1:0]   left_thr_m;
	logic [SAMPLE_BITS-1:0]   right_thr_m;
	logic                     line_seen;
	logic signed [ErrW-1:0]   err_w;
	logic signed [ErrW-1:0]   prev_w;
	logic signed [SumW-1:0]   sum_w;
	logic [SumW-1:0]          mag_w;
	logic [GainW:0]           shifted_w;
	logic                     fits_w;
	logic signed [ResW-1:0]   corr_w;
	logic signed [ResW-1:0]   base_w;
	logic signed [ResW-1:0]   left_v;
	logic signed [ResW-1:0]   right_v;

	// Clamp a signed level to 0..max_level
	function automatic logic [LevelW-1:0] clamp_level(
		input logic signed [ResW-1:0] v,
		input logic [LevelW-1:0]      lim
	);
		logic signed [ResW-1:0] lim_s;
		lim_s = $signed({{(ResW - LevelW){1'b0}}, lim});
		if (v < 0) begin
			return '0;
		end else if (v > lim_s) begin
			return lim;
		end else begin
			return v[LevelW-1:0];
		end
	endfunction

	// Take thresholds in their low sample bits
	assign left_thr_m  = SAMPLE_BITS'(left_thr_q);
	assign right_thr_m = SAMPLE_BITS'(right_thr_q);
	assign line_seen   = (left_q > left_thr_m) || (right_q > right_thr_m);

	// Error and the previous error it is measured against
	assign err_w  = $signed({1'b0, left_q}) - $signed({1'b0, right_q});
	assign prev_w = clear_q ? '0 : prev_error_q;

	// Summed PD term and its magnitude
	assign sum_w = prod_p_q + prod_d_q;
	assign mag_w = sum_w[SumW-1] ? SumW'(-sum_w) : SumW'(sum_w);

	// One restoring divide step
	assign shifted_w = {rem_q, quot_q[MagW-1]};
	assign fits_w    = shifted_w >= {1'b0, div_q};

	// Signed correction applied to the base level
	assign corr_w  = neg_q ? -$signed({2'b00, quot_q}) : $signed({2'b00, quot_q});
	assign base_w  = $signed({{(ResW - LevelW){1'b0}}, base_q});
	assign left_v  = base_w - corr_w;
	assign right_v = base_w + corr_w;

	// Configuration writes; unknown indexes cannot occur with a 3-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_thr_q  <= '0;
			right_thr_q <= '0;
			prop_q      <= pdlf_pkg::PropGainRst;
			deriv_q     <= pdlf_pkg::DerivGainRst;
			gdiv_q      <= pdlf_pkg::GainDivRst;
			base_q      <= '0;
			max_q       <= '0;
			back_q      <= '0;
		end else if (cfg_we) begin
			unique case (pdlf_pkg::cfg_reg_t'(cfg_index))
				pdlf_pkg::REG_LEFT_THRESHOLD:  left_thr_q  <= cfg_wdata[pdlf_pkg::SampleW-1:0];
				pdlf_pkg::REG_RIGHT_THRESHOLD: right_thr_q <= cfg_wdata[pdlf_pkg::SampleW-1:0];
				pdlf_pkg::REG_PROP_GAIN:       prop_q      <= cfg_wdata[GainW-1:0];
				pdlf_pkg::REG_DERIV_GAIN:      deriv_q     <= cfg_wdata[GainW-1:0];
				pdlf_pkg::REG_GAIN_DIVISOR:    gdiv_q      <= cfg_wdata[GainW-1:0];
				pdlf_pkg::REG_BASE_LEVEL:      base_q      <= cfg_wdata[LevelW-1:0];
				pdlf_pkg::REG_MAX_LEVEL:       max_q       <= cfg_wdata[LevelW-1:0];
				pdlf_pkg::REG_BACK_LEVEL:      back_q      <= cfg_wdata[LevelW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, shared divider and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_error_q <= '0;
			m_tvalid_q   <= 1'b0;
			left_q       <= '0;
			right_q      <= '0;
			clear_q      <= 1'b0;
			lost_q       <= 1'b0;
			err_q        <= '0;
			delta_q      <= '0;
			prod_p_q     <= '0;
			prod_d_q     <= '0;
			neg_q        <= 1'b0;
			quot_q       <= '0;
			rem_q        <= '0;
			div_q        <= '0;
			cnt_q        <= '0;
			left_lvl_q   <= '0;
			right_lvl_q  <= '0;
			m_tuser_q    <= 1'b0;
			m_left_q     <= '0;
			m_right_q    <= '0;
		end else begin
			// Drop the output word once taken, unless a finished item refills it
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					// Capture the samples in their low sample bits
					if (s_tvalid) begin
						left_q  <= SAMPLE_BITS'(s_tdata[pdlf_pkg::SampleW-1:0]);
						right_q <= SAMPLE_BITS'(s_tdata[2*pdlf_pkg::SampleW-1:pdlf_pkg::SampleW]);
						clear_q <= s_tuser;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					// Classify, form error and change, update history
					lost_q  <= !line_seen;
					err_q   <= err_w;
					delta_q <= DeltaW'(err_w) - DeltaW'(prev_w);
					if (line_seen) begin
						prev_error_q <= err_w;
						state_q      <= ST_MUL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL: begin
					prod_p_q <= ProdW'($signed({1'b0, prop_q})) * ProdW'(err_q);
					prod_d_q <= ProdW'($signed({1'b0, deriv_q})) * ProdW'(delta_q);
					state_q  <= ST_SUM;
				end
				ST_SUM: begin
					// Load the divider with the magnitude; zero divisor acts as one
					neg_q   <= sum_w[SumW-1];
					quot_q  <= mag_w[MagW-1:0];
					rem_q   <= '0;
					div_q   <= (gdiv_q == '0) ? GainW'(1) : gdiv_q;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// One quotient bit per cycle
					if (fits_w) begin
						rem_q <= GainW'(shifted_w - {1'b0, div_q});
					end else begin
						rem_q <= shifted_w[GainW-1:0];
					end
					quot_q <= {quot_q[MagW-2:0], fits_w};
					cnt_q  <= cnt_q + CntW'(1);
					if (cnt_q == CntW'(MagW - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					left_lvl_q  <= clamp_level(left_v, max_q);
					right_lvl_q <= clamp_level(right_v, max_q);
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= lost_q;
						m_left_q   <= lost_q ? back_q : left_lvl_q;
						m_right_q  <= lost_q ? back_q : right_lvl_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = {m_right_q, m_left_q};

	// Checks on the sequencer and the divider
	`PDLF_ASSERT_SAME(a_rem_below_div, state_q == ST_DIV, rem_q < div_q,
		"divider remainder not below divisor")
	`PDLF_ASSERT_SAME(a_div_nonzero, state_q == ST_DIV, div_q != '0,
		"divider running with a zero divisor")
	`PDLF_ASSERT_NEXT(a_lost_keeps_history, state_q == ST_ERR && !line_seen,
		$stable(prev_error_q), "lost line changed the stored error")
	`PDLF_ASSERT_NEXT(a_stall_holds_done, state_q == ST_DONE && m_tvalid_q && !m_tready,
		state_q == ST_DONE, "result left done state while output was blocked")
	`PDLF_ASSERT_SAME(a_out_from_done, $rose(m_tvalid_q), $past(state_q == ST_DONE),
		"output word appeared without a finished item")

endmodule

>>> tb/pd_line_follow_steering_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_line_follow_steering_core_tb
// Self-checking bench for the PD line-follow steering core.
// ----------------------------------------------------------------------------
// Drives sample words through the slave stream and compares every drive word
// on the master stream against a PD steering predictor kept in step with the
// bench's own copy of the registers and the stored error. Directed cases hit
// the reset state, field extremes, lost line, history clear, a zero divisor
// and a base level above the clamp. Random phases then reprogram all registers
// and stream tracking runs, noise and lost-line words, with random gaps and
// back-pressure on both streams.
// ----------------------------------------------------------------------------
module pd_line_follow_steering_core_tb;

	localparam int SampleMax = (1 << pdlf_pkg::SampleW) - 1;
	localparam int LevelMax  = (1 << pdlf_pkg::LevelW) - 1;

	typedef logic [pdlf_pkg::SampleW-1:0] sample_t;
	typedef logic [pdlf_pkg::GainW-1:0]   gain_t;
	typedef logic [pdlf_pkg::LevelW-1:0]  level_t;

	typedef struct packed {
		logic   dir;
		level_t left;
		level_t right;
	} drive_t;

	// DUT ports; the bench-driven ones are known from time zero
	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [pdlf_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [pdlf_pkg::CfgW-1:0]     cfg_wdata = '0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [pdlf_pkg::InDataW-1:0]  s_tdata   = '0;   // [11:0] left_sample, [23:12] right_sample
	logic                          s_tuser   = 1'b0; // [0] clear_history
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [pdlf_pkg::OutDataW-1:0] m_tdata;          // [15:0] left_level, [31:16] right_level
	logic                          m_tuser;          // [0] drive_dir

	// Shadow registers and stored error of the predictor
	sample_t thr_left  = '0;
	sample_t thr_right = '0;
	gain_t   kp        = pdlf_pkg::PropGainRst;
	gain_t   kd        = pdlf_pkg::DerivGainRst;
	gain_t   kdiv      = pdlf_pkg::GainDivRst;
	level_t  base_lvl  = '0;
	level_t  max_lvl   = '0;
	level_t  back_lvl  = '0;
	longint  last_err  = 0;

	drive_t pending_drives[$];

	int fail_count     = 0;
	int samples_sent   = 0;
	int lost_sent      = 0;
	int clears_sent    = 0;
	int drives_checked = 0;
	int reg_writes     = 0;
	int tx_gap_max     = 19;
	int rx_gap_max     = 19;
	int rx_stall       = 0;
	int walk_l         = 2048;
	int walk_r         = 2048;

	pd_line_follow_steering_core #(
		.SAMPLE_BITS(pdlf_pkg::SampleBitsDef)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#15_000_000;
		$display("FAIL pd_line_follow_steering_core");
		$finish;
	end

	// Clamp a wide level into 0..max_level
	function automatic level_t clamp_level(input longint v);
		if (v < 0)
			return '0;
		if (v > longint'(max_lvl))
			return max_lvl;
		return v[pdlf_pkg::LevelW-1:0];
	endfunction

	// Steering for one sample pair; advances the stored error unless the line is lost
	function automatic drive_t predict_drive(input sample_t l, input sample_t r,
			input logic clr);
		drive_t d;
		longint err;
		longint chg;
		longint corr;
		longint divisor;
		if (l <= thr_left && r <= thr_right) begin
			d.dir   = 1'b1;
			d.left  = back_lvl;
			d.right = back_lvl;
			return d;
		end
		err      = longint'(l) - longint'(r);
		chg      = err - (clr ? 64'sd0 : last_err);
		last_err = err;
		corr     = longint'(kp) * err + longint'(kd) * chg;
		divisor  = (kdiv == '0) ? 64'sd1 : longint'(kdiv);
		corr     = corr / divisor;
		d.dir    = 1'b0;
		d.left   = clamp_level(longint'(base_lvl) - corr);
		d.right  = clamp_level(longint'(base_lvl) + corr);
		return d;
	endfunction

	// Take drive words with random back-pressure and compare each one
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drives.size() == 0) begin
				$display("%0t: unexpected drive word dir=%0b left=%0d right=%0d",
					$time, m_tuser, m_tdata[15:0], m_tdata[31:16]);
				fail_count++;
			end else begin
				want = pending_drives.pop_front();
				if (m_tuser !== want.dir) begin
					$display("%0t: drive_dir expected %0b actual %0b",
						$time, want.dir, m_tuser);
					fail_count++;
				end
				if (m_tdata[15:0] !== want.left) begin
					$display("%0t: left_level expected %0d actual %0d",
						$time, want.left, m_tdata[15:0]);
					fail_count++;
				end
				if (m_tdata[31:16] !== want.right) begin
					$display("%0t: right_level expected %0d actual %0d",
						$time, want.right, m_tdata[31:16]);
					fail_count++;
				end
			end
			drives_checked++;
			rx_stall = $urandom_range(0, rx_gap_max);
		end else if (rx_stall > 0) begin
			rx_stall--;
		end
		m_tready <= (rx_stall == 0);
	end

	// Send one sample word after a random gap and log its expected drive word
	task automatic send_sample(input sample_t l, input sample_t r, input logic clr);
		int gap;
		drive_t d;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r, l};
		s_tuser  <= clr;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		d = predict_drive(l, r, clr);
		pending_drives.push_back(d);
		samples_sent++;
		if (d.dir)
			lost_sent++;
		if (clr)
			clears_sent++;
	endtask

	// Hold off the sender until every drive word has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write one register and mirror it, masked to the register width
	task automatic write_reg(input pdlf_pkg::cfg_reg_t idx,
			input logic [pdlf_pkg::CfgW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pdlf_pkg::REG_LEFT_THRESHOLD:  thr_left  = value[pdlf_pkg::SampleW-1:0];
			pdlf_pkg::REG_RIGHT_THRESHOLD: thr_right = value[pdlf_pkg::SampleW-1:0];
			pdlf_pkg::REG_PROP_GAIN:       kp        = value[pdlf_pkg::GainW-1:0];
			pdlf_pkg::REG_DERIV_GAIN:      kd        = value[pdlf_pkg::GainW-1:0];
			pdlf_pkg::REG_GAIN_DIVISOR:    kdiv      = value[pdlf_pkg::GainW-1:0];
			pdlf_pkg::REG_BASE_LEVEL:      base_lvl  = value[pdlf_pkg::LevelW-1:0];
			pdlf_pkg::REG_MAX_LEVEL:       max_lvl   = value[pdlf_pkg::LevelW-1:0];
			pdlf_pkg::REG_BACK_LEVEL:      back_lvl  = value[pdlf_pkg::LevelW-1:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Program all registers; with noise set, junk goes into unused upper bits
	task automatic apply_config(input sample_t lt, input sample_t rt,
			input gain_t p, input gain_t d, input gain_t dv,
			input level_t base, input level_t mx,
			input level_t back, input logic noise);
		write_reg(pdlf_pkg::REG_LEFT_THRESHOLD,  {noise ? 4'($urandom) : 4'h0, lt});
		write_reg(pdlf_pkg::REG_RIGHT_THRESHOLD, {noise ? 4'($urandom) : 4'h0, rt});
		write_reg(pdlf_pkg::REG_PROP_GAIN,       {noise ? 8'($urandom) : 8'h0, p});
		write_reg(pdlf_pkg::REG_DERIV_GAIN,      {noise ? 8'($urandom) : 8'h0, d});
		write_reg(pdlf_pkg::REG_GAIN_DIVISOR,    {noise ? 8'($urandom) : 8'h0, dv});
		write_reg(pdlf_pkg::REG_BASE_LEVEL,      base);
		write_reg(pdlf_pkg::REG_MAX_LEVEL,       mx);
		write_reg(pdlf_pkg::REG_BACK_LEVEL,      back);
	endtask

	// Pick a register value, leaning on both ends of its range
	function automatic int pick_extreme(input int hi);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return hi;
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	// Draw a fresh register setting for a random phase
	task automatic randomize_config();
		int lt;
		int rt;
		int dv;
		lt = ($urandom_range(0, 7) == 0) ? pick_extreme(SampleMax) : $urandom_range(0, 3000);
		rt = ($urandom_range(0, 7) == 0) ? pick_extreme(SampleMax) : $urandom_range(0, 3000);
		dv = pick_extreme(255);
		apply_config(sample_t'(lt), sample_t'(rt), gain_t'(pick_extreme(255)),
			gain_t'(pick_extreme(255)), gain_t'(dv),
			level_t'(pick_extreme(LevelMax)), level_t'(pick_extreme(LevelMax)),
			level_t'(pick_extreme(LevelMax)), $urandom_range(0, 3) == 0);
	endtask

	// Next sample pair: most often a drifting track, else lost-line, extremes or noise
	task automatic next_sample(output sample_t l, output sample_t r);
		int mode;
		int lv;
		int rv;
		mode = $urandom_range(0, 99);
		if (mode < 15) begin
			lv = $urandom_range(0, thr_left);
			rv = $urandom_range(0, thr_right);
		end else if (mode < 25) begin
			lv = $urandom_range(0, 1) ? SampleMax : 0;
			rv = $urandom_range(0, 1) ? SampleMax : 0;
		end else if (mode < 70) begin
			lv = walk_l + int'($urandom_range(0, 128)) - 64;
			rv = walk_r + int'($urandom_range(0, 128)) - 64;
		end else begin
			lv = $urandom_range(0, SampleMax);
			rv = $urandom_range(0, SampleMax);
		end
		lv = (lv < 0) ? 0 : (lv > SampleMax) ? SampleMax : lv;
		rv = (rv < 0) ? 0 : (rv > SampleMax) ? SampleMax : rv;
		walk_l = lv;
		walk_r = rv;
		l = sample_t'(lv);
		r = sample_t'(rv);
	endtask

	// Reset values: zero thresholds, unit gain, zero levels
	task automatic test_reset_state();
		send_sample(12'd0, 12'd0, 1'b0);
		send_sample(12'd4095, 12'd0, 1'b0);
		send_sample(12'd0, 12'd4095, 1'b1);
	endtask

	// Largest gains and samples so the correction clamps on both wheels
	task automatic test_field_extremes();
		wait_idle();
		apply_config(12'd0, 12'd0, 8'd255, 8'd255, 8'd1, 16'd32768, 16'hFFFF, 16'hFFFF, 1'b0);
		send_sample(12'd4095, 12'd0, 1'b1);
		send_sample(12'd0, 12'd4095, 1'b0);
		send_sample(12'd4095, 12'd4095, 1'b0);
		send_sample(12'd1, 12'd0, 1'b1);
		send_sample(12'd0, 12'd1, 1'b0);
	endtask

	// Lost line reverses and keeps the stored error, clear or not
	task automatic test_line_lost();
		wait_idle();
		apply_config(12'd2000, 12'd3000, 8'd3, 8'd2, 8'd4, 16'd30000, 16'd50000, 16'd12345,
			1'b0);
		send_sample(12'd2001, 12'd100, 1'b1);
		send_sample(12'd2000, 12'd3000, 1'b1);
		send_sample(12'd1500, 12'd2500, 1'b0);
		send_sample(12'd1000, 12'd3001, 1'b0);
		send_sample(12'd4095, 12'd4095, 1'b0);
	endtask

	// Derivative only, odd divisor to show truncation of negative terms
	task automatic test_clear_history();
		wait_idle();
		apply_config(12'd0, 12'd0, 8'd0, 8'd7, 8'd3, 16'd1000, 16'd2000, 16'd0, 1'b1);
		send_sample(12'd10, 12'd0, 1'b1);
		send_sample(12'd0, 12'd10, 1'b0);
		send_sample(12'd0, 12'd10, 1'b1);
		send_sample(12'd5, 12'd9, 1'b0);
	endtask

	// A divisor of zero acts as one
	task automatic test_zero_divisor();
		wait_idle();
		apply_config(12'd100, 12'd100, 8'd5, 8'd1, 8'd0, 16'd20000, 16'd40000, 16'd500, 1'b0);
		send_sample(12'd4000, 12'd200, 1'b1);
		send_sample(12'd300, 12'd3900, 1'b0);
	endtask

	// Base level above the clamp still clamps to max_level
	task automatic test_base_above_max();
		wait_idle();
		apply_config(12'd0, 12'd0, 8'd2, 8'd0, 8'd2, 16'd60000, 16'd1000, 16'd0, 1'b0);
		send_sample(12'd10, 12'd0, 1'b0);
		send_sample(12'd0, 12'd4095, 1'b1);
	endtask

	// Random phases, each with a fresh register setting and varying stream pressure
	task automatic test_random_tracking(input int n_items);
		sample_t l;
		sample_t r;
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			randomize_config();
			for (int i = 0; i < n_items / 8; i++) begin
				if (i % 40 == 0) begin
					tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
					rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
				end
				if ($urandom_range(0, 79) == 0)
					wait_idle();
				next_sample(l, r);
				send_sample(l, r, $urandom_range(0, 7) == 0);
			end
		end
		tx_gap_max = 19;
		rx_gap_max = 19;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_field_extremes();
		test_line_lost();
		test_clear_history();
		test_zero_divisor();
		test_base_above_max();
		test_random_tracking(1656);

		// Drain, then watch for stray words past the longest item latency
		wait_idle();
		repeat (40) @(posedge clk);

		$display("Covered %0d sample words (%0d lost-line, %0d history clears), %0d reg writes.",
			samples_sent, lost_sent, clears_sent, reg_writes);
		$display("Checked %0d drive words, %0d mismatches.", drives_checked, fail_count);
		if (fail_count == 0 && pending_drives.size() == 0) begin
			$display("PASS pd_line_follow_steering_core");
		end else begin
			$display("FAIL pd_line_follow_steering_core");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pdlf_pkg.sv
rtl/pd_line_follow_steering_core.sv
tb/pd_line_follow_steering_core_tb.sv
